>>> rtl/dtsw_pkg.sv
// Package for the binary64 to 32-bit scalar word encoder.
// Holds the transfer structs, kind and status codes. No dependencies.
`default_nettype none
package dtsw_pkg;
	typedef enum logic [1:0] {
		KIND_FLOAT = 2'd0,
		KIND_INT   = 2'd1,
		KIND_UINT  = 2'd2,
		KIND_BOOL  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_FINITE = 2'd1,
		ST_RANGE      = 2'd2,
		ST_INVALID    = 2'd3
	} status_t;

	localparam logic [62:0] F32_MAX_MAG = 63'h47EFFFFFE0000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] value_bits;
	} in_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  status;
	} out_item_t;
endpackage
`default_nettype wire

>>> rtl/double_to_scalar_word_encoder_core.sv
// Top level of the binary64 to 32-bit scalar word encoder.
// Depends on dtsw_pkg and dtsw_convert.
//
// Usage:
//  - Input channel in_valid/in_stall/in_item carries kind and a binary64
//    bit pattern; a transfer happens when in_valid is high and in_stall low.
//  - Output channel out_valid/out_stall/out_item carries the 32-bit word and
//    a status code (ok, not finite, float range, integer invalid).
//  - Three register stages: decode, shift/round, final add and select.
//    out_valid rises once the item has passed the stage-1, stage-2 and
//    output registers; out_stall can hold it there before the transfer.
//  - Throughput is one item per cycle while no result is held by
//    out_stall; the stage-2 shifts of the significand set the cycle time.
//  - The pipeline advances whenever the output register is empty or being
//    taken. While a result is held by out_stall every stage freezes,
//    bubbles included, and in_stall is high for exactly those cycles.
//  - Reset (arst_n low) clears all valid bits; no item is in flight after.
`default_nettype none
module double_to_scalar_word_encoder_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire dtsw_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output dtsw_pkg::out_item_t      out_item
);
	logic en;

	// whole pipe moves together; stops only when the output is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	dtsw_convert u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_item  (out_item)
	);
endmodule
`default_nettype wire

>>> rtl/dtsw_convert.sv
// Three-stage conversion datapath with valid bits and a shared stall.
// Depends on dtsw_pkg.
`default_nettype none
module dtsw_convert (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire dtsw_pkg::in_item_t  in_item,
	output logic                     out_valid,
	output dtsw_pkg::out_item_t      out_item
);
	// stage 1: decode, shift amounts, early status
	logic        v_s1;
	logic [1:0]  kind_s1;
	logic        sign_s1;
	logic [52:0] sig_s1;
	logic [5:0]  fshift_s1;   // 29..60
	logic [7:0]  fbase_s1;
	logic        fzero_s1;
	logic [5:0]  ishift_s1;   // 52-ue, 21..52
	logic        ibad_s1;
	logic        izero_s1;
	logic [1:0]  st_s1;

	logic [10:0] e_in;
	logic [51:0] fr_in;
	logic [11:0] ue_in;
	logic [11:0] fs_calc;
	logic        nf_in, rng_in;

	always_comb begin
		e_in    = in_item.value_bits[62:52];
		fr_in   = in_item.value_bits[51:0];
		ue_in   = {1'b0, e_in} - 12'd1023;
		fs_calc = 12'd29 + 12'd897 - {1'b0, e_in}; // 29 + (-126 - ue)
		nf_in   = (e_in == 11'h7FF);
		rng_in  = in_item.value_bits[62:0] > dtsw_pkg::F32_MAX_MAG;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1  <= in_item.kind;
			sign_s1  <= in_item.value_bits[63];
			sig_s1   <= {1'b1, fr_in};
			fzero_s1 <= (e_in == 11'd0);
			izero_s1 <= (e_in == 11'd0) && (fr_in == 52'd0);
			// hidden bit of the rounded significand adds one to the exponent
			if (e_in >= 11'd897) begin
				fshift_s1 <= 6'd29;
				fbase_s1  <= 8'(e_in - 11'd897);
			end else begin
				fshift_s1 <= (fs_calc > 12'd60) ? 6'd60 : fs_calc[5:0];
				fbase_s1  <= 8'd0;
			end
			ibad_s1   <= (e_in < 11'd1023) || (e_in > 11'd1054);
			ishift_s1 <= 6'(12'd52 - ue_in);
			if (nf_in)
				st_s1 <= dtsw_pkg::ST_NOT_FINITE;
			else if (in_item.kind == dtsw_pkg::KIND_FLOAT && rng_in)
				st_s1 <= dtsw_pkg::ST_RANGE;
			else
				st_s1 <= dtsw_pkg::ST_OK;
		end
	end

	// stage 2: shifts, rounding decision, fraction check
	logic        v_s2;
	logic [1:0]  kind_s2;
	logic        sign_s2;
	logic [1:0]  st_s2;
	logic [23:0] fq_s2;
	logic        rup_s2;
	logic [7:0]  fbase_s2;
	logic        fzero_s2;
	logic [32:0] mag_s2;
	logic        ibad_s2;
	logic        izero_s2;

	// 64 bits wide so the half point stays nonzero for shifts past 53
	logic [63:0] q_c, rem_c, half_c;
	logic [52:0] imask_c;
	always_comb begin
		q_c     = {11'd0, sig_s1} >> fshift_s1;
		rem_c   = {11'd0, sig_s1} & ((64'd1 << fshift_s1) - 64'd1);
		half_c  = 64'd1 << (fshift_s1 - 6'd1);
		imask_c = (53'd1 << ishift_s1) - 53'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2  <= kind_s1;
			sign_s2  <= sign_s1;
			st_s2    <= st_s1;
			fq_s2    <= q_c[23:0];
			rup_s2   <= (rem_c > half_c) || ((rem_c == half_c) && q_c[0]);
			fbase_s2 <= fbase_s1;
			fzero_s2 <= fzero_s1;
			mag_s2   <= 33'(sig_s1 >> ishift_s1);
			ibad_s2  <= ibad_s1 || ((sig_s1 & imask_c) != 53'd0);
			izero_s2 <= izero_s1;
		end
	end

	// stage 3: final add, integer range checks, result select
	logic [31:0] fw_c, iw_c, w_c;
	logic [1:0]  ist_c, st_c;
	always_comb begin
		fw_c = fzero_s2 ? {sign_s2, 31'd0} :
			{sign_s2, 31'({fbase_s2, 23'd0}) + 31'(fq_s2) + 31'(rup_s2)};
		ist_c = dtsw_pkg::ST_OK;
		iw_c  = 32'd0;
		if (izero_s2) begin
			ist_c = dtsw_pkg::ST_OK;
		end else if (ibad_s2) begin
			ist_c = dtsw_pkg::ST_INVALID;
		end else if (kind_s2 == dtsw_pkg::KIND_INT) begin
			if (sign_s2 ? (mag_s2 > 33'h80000000) : (mag_s2 > 33'h7FFFFFFF))
				ist_c = dtsw_pkg::ST_INVALID;
			else
				iw_c = sign_s2 ? 32'(33'd0 - mag_s2) : mag_s2[31:0];
		end else if (sign_s2 || (kind_s2 == dtsw_pkg::KIND_BOOL && mag_s2 > 33'd1)) begin
			ist_c = dtsw_pkg::ST_INVALID;
		end else begin
			iw_c = mag_s2[31:0];
		end
		if (st_s2 != dtsw_pkg::ST_OK) begin
			st_c = st_s2;
			w_c  = 32'd0;
		end else if (kind_s2 == dtsw_pkg::KIND_FLOAT) begin
			st_c = dtsw_pkg::ST_OK;
			w_c  = fw_c;
		end else begin
			st_c = ist_c;
			w_c  = (ist_c == dtsw_pkg::ST_OK) ? iw_c : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item.word   <= w_c;
			out_item.status <= st_c;
		end
	end
endmodule
`default_nettype wire

>>> rtl/dtsw_checker.sv
// Port-level checks for the encoder, bound to the top level.
// Depends on dtsw_pkg.
`default_nettype none
module dtsw_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire dtsw_pkg::in_item_t  in_item,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire dtsw_pkg::out_item_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output changed under stall");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != dtsw_pkg::ST_OK |-> out_item.word == 32'd0)
		else $error("nonzero word on error");
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing after three cycles");
endmodule

bind double_to_scalar_word_encoder_core dtsw_checker u_dtsw_checker (.*);
`default_nettype wire
